>>> sv/rgbw_dimmer_with_fade_unit_assert.svh
// Assertion macros used by the dimmer controller RTL.
`ifndef RGBW_DIMMER_WITH_FADE_UNIT_ASSERT_SVH
`define RGBW_DIMMER_WITH_FADE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RDF_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RDF_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> sv/rdf_pkg.sv
package rdf_pkg;

    // operations
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_ACTION = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BUTTON_STEP  = 2'd0;
    localparam logic [1:0] CFG_DIMMED_LEVEL = 2'd1;
    localparam logic [1:0] CFG_FADE_TIME    = 2'd2;

    // button actions
    localparam logic [4:0] ACT_ON           = 5'd0;
    localparam logic [4:0] ACT_OFF          = 5'd1;
    localparam logic [4:0] ACT_TOGGLE       = 5'd2;
    localparam logic [4:0] ACT_BRIGHTEN     = 5'd3;
    localparam logic [4:0] ACT_DIM          = 5'd4;
    localparam logic [4:0] ACT_RED_UP       = 5'd5;
    localparam logic [4:0] ACT_RED_DOWN     = 5'd6;
    localparam logic [4:0] ACT_GREEN_UP     = 5'd7;
    localparam logic [4:0] ACT_GREEN_DOWN   = 5'd8;
    localparam logic [4:0] ACT_BLUE_UP      = 5'd9;
    localparam logic [4:0] ACT_BLUE_DOWN    = 5'd10;
    localparam logic [4:0] ACT_WHITE_UP     = 5'd11;
    localparam logic [4:0] ACT_WHITE_DOWN   = 5'd12;
    localparam logic [4:0] ACT_RGB_UP       = 5'd13;
    localparam logic [4:0] ACT_RGB_DOWN     = 5'd14;
    localparam logic [4:0] ACT_RGB_ON       = 5'd15;
    localparam logic [4:0] ACT_RGB_OFF      = 5'd16;
    localparam logic [4:0] ACT_RGB_TOGGLE   = 5'd17;
    localparam logic [4:0] ACT_WHITE_ON     = 5'd18;
    localparam logic [4:0] ACT_WHITE_OFF    = 5'd19;
    localparam logic [4:0] ACT_WHITE_TOGGLE = 5'd20;
    localparam logic [4:0] ACT_RGB_DIMMED   = 5'd21;
    localparam logic [4:0] ACT_WHITE_DIMMED = 5'd22;
    localparam logic [4:0] ACT_ALL_DIMMED   = 5'd23;
    localparam logic [4:0] ACT_ITER_RGB     = 5'd24;
    localparam logic [4:0] ACT_ITER_WHITE   = 5'd25;
    localparam logic [4:0] ACT_ITER_ALL     = 5'd26;

    // limits
    localparam logic [7:0] COLOR_MAX  = 8'd255;
    localparam logic [6:0] LEVEL_MAX  = 7'd100;
    localparam logic [6:0] HOLD_LOW   = 7'd10;
    localparam logic [2:0] HOLD_ITEMS = 3'd5;

    // divider step counts (count register loads steps - 1)
    localparam logic [3:0] DIV1_LAST = 4'd15;
    localparam logic [3:0] DIV2_LAST = 4'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APPLY,
        S_DIV1,
        S_DIV2S,
        S_DIV2,
        S_RAMP,
        S_WAIT1,
        S_WAIT2
    } rdf_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic div1_init;
        logic div1_step;
        logic div2_init;
        logic div2_step;
        logic ramp;
        logic load_report;
    } rdf_cmd_t;

    typedef struct packed {
        logic op_apply;
        logic tick_go;
        logic apply_emit;
        logic fade_off;
        logic cnt_zero;
        logic ramp_changed;
    } rdf_stat_t;

    function automatic logic [6:0] sat100(input logic [7:0] v);
        logic [6:0] r;
        r = (v > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : v[6:0];
        return r;
    endfunction

    function automatic logic [7:0] step_up(input logic [7:0] v, input logic [6:0] s,
                                           input logic [7:0] lim);
        logic [8:0] sum;
        sum = {1'b0, v} + {2'b00, s};
        return (sum > {1'b0, lim}) ? lim : sum[7:0];
    endfunction

    function automatic logic [7:0] step_down(input logic [7:0] v, input logic [6:0] s);
        logic [7:0] s8;
        s8 = {1'b0, s};
        return (s8 > v) ? 8'd0 : v - s8;
    endfunction

    // move drive toward target by st, stop at target
    function automatic logic [7:0] ramp(input logic [7:0] drv, input logic [7:0] tgt,
                                        input logic [7:0] st);
        logic [8:0] up;
        logic [8:0] lo;
        logic [7:0] r;
        up = {1'b0, drv} + {1'b0, st};
        lo = {1'b0, tgt} + {1'b0, st};
        r  = drv;
        if (tgt > drv)
        begin
            r = (up > {1'b0, tgt}) ? tgt : up[7:0];
        end
        else if (tgt < drv)
        begin
            r = ({1'b0, drv} < lo) ? tgt : drv - st;
        end
        return r;
    endfunction

endpackage

>>> sv/rdf_ctrl.sv
module rdf_ctrl
    import rdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  rdf_stat_t stat,
    output rdf_cmd_t  cmd
);

`include "rgbw_dimmer_with_fade_unit_assert.svh"

    rdf_state_t state_reg;
    rdf_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.op_apply)
                    state_next = S_APPLY;
                else if (stat.tick_go)
                    state_next = S_DIV1;
                else
                    state_next = S_IDLE;
            end
            S_APPLY:
            begin
                if (!stat.apply_emit)
                    state_next = S_IDLE;
                else if (stat.fade_off)
                    state_next = S_WAIT1;
                else
                    state_next = S_WAIT2;
            end
            S_DIV1:
            begin
                if (stat.cnt_zero)
                    state_next = S_DIV2S;
            end
            S_DIV2S:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (stat.cnt_zero)
                    state_next = S_RAMP;
            end
            S_RAMP:
            begin
                state_next = stat.ramp_changed ? S_WAIT2 : S_IDLE;
            end
            S_WAIT1:
            begin
                if (!out_stall)
                    state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_DECODE: cmd.div1_init = 1'b1;
            S_APPLY:  cmd.apply     = 1'b1;
            S_DIV1:   cmd.div1_step = 1'b1;
            S_DIV2S:  cmd.div2_init = 1'b1;
            S_DIV2:   cmd.div2_step = 1'b1;
            S_RAMP:   cmd.ramp      = 1'b1;
            S_WAIT1:
            begin
                out_valid       = 1'b1;
                cmd.load_report = !out_stall;
            end
            S_WAIT2:  out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

    `RDF_ASSERT_NOW(a_no_input_while_out, out_valid, in_stall, "input taken while result pending")
    `RDF_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_reg == S_DECODE,
        "accepted transaction not decoded")
    `RDF_ASSERT_NEXT(a_report_follows, (state_reg == S_WAIT1) && !out_stall,
        out_valid && (state_reg == S_WAIT2), "report missing after drive result")

endmodule

>>> sv/rdf_dp.sv
module rdf_dp
    import rdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rdf_cmd_t    cmd,
    output rdf_stat_t   stat,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  operation,
    input  logic [4:0]  action_code,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  color_level_in,
    input  logic [7:0]  white_level_in,
    input  logic [15:0] elapsed_ms,
    output logic        result_kind,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [6:0]  color_level_out,
    output logic [6:0]  white_level_out,
    output logic        last
);

    // configuration
    logic [6:0]  step_reg;
    logic [6:0]  dimmed_reg;
    logic [15:0] fade_reg;

    // captured transaction
    logic [1:0]  op_reg;
    logic [4:0]  act_reg;
    logic [7:0]  r_in_reg, g_in_reg, b_in_reg, cl_in_reg, wl_in_reg;
    logic [15:0] ms_reg;

    // targets, memory of levels, iterate state, drive values
    logic [7:0] tr_reg, tg_reg, tb_reg;
    logic [6:0] tcl_reg, twl_reg, rc_reg, rw_reg;
    logic       down_reg;
    logic [2:0] hold_reg;
    logic [7:0] dr_reg, dg_reg, db_reg;
    logic [6:0] dcl_reg, dwl_reg;

    // dividers
    logic [3:0]  cnt_reg;
    logic [15:0] q1_reg, rem1_reg;
    logic [7:0]  qa_reg, qb_reg;
    logic [8:0]  rema_reg, remb_reg;
    logic [15:0] div_reg;

    // output register
    logic       o_kind_reg, o_last_reg;
    logic [7:0] o_r_reg, o_g_reg, o_b_reg;
    logic [6:0] o_cl_reg, o_wl_reg;

    // apply logic
    logic [7:0] tr_next, tg_next, tb_next;
    logic [6:0] tcl_next, twl_next, rc_next, rw_next;
    logic       down_next;
    logic [2:0] hold_next;
    logic       emit;
    logic       set_r, set_g, set_b, set_cl, set_wl;
    logic [7:0] v_r, v_g, v_b;
    logic [6:0] v_cl, v_wl, dl;
    logic [6:0] it_cs, it_ws, it_twl, it_lvl;
    logic       it_chk, it_cond;
    logic [2:0] it_h;

    // divider and ramp logic
    logic [16:0] sh1;
    logic [16:0] sh1_sub;
    logic [15:0] sha, shb;
    logic [15:0] div_eff;
    logic [7:0]  cs8, ls8;
    logic [7:0]  dr_next, dg_next, db_next, dcl8_next, dwl8_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 7'd10;
            dimmed_reg <= 7'd20;
            fade_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUTTON_STEP:  step_reg   <= cfg_data[6:0];
                CFG_DIMMED_LEVEL: dimmed_reg <= cfg_data[6:0];
                CFG_FADE_TIME:    fade_reg   <= cfg_data;
                default:          step_reg   <= step_reg;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            act_reg   <= action_code;
            r_in_reg  <= red_in;
            g_in_reg  <= green_in;
            b_in_reg  <= blue_in;
            cl_in_reg <= color_level_in;
            wl_in_reg <= white_level_in;
            ms_reg    <= elapsed_ms;
        end
    end

    assign stat.op_apply = (op_reg == OP_SET) || (op_reg == OP_ACTION);
    assign stat.tick_go  = (op_reg == OP_TICK) && (fade_reg != 16'd0) && (ms_reg != 16'd0);
    assign stat.fade_off = (fade_reg == 16'd0);
    assign stat.cnt_zero = (cnt_reg == 4'd0);
    assign stat.apply_emit = emit;

    // iterate helpers
    always_comb
    begin
        dl     = sat100({1'b0, dimmed_reg});
        it_cs  = ((act_reg == ACT_ITER_RGB) || (act_reg == ACT_ITER_ALL)) ? step_reg : 7'd0;
        it_ws  = ((act_reg == ACT_ITER_WHITE) || (act_reg == ACT_ITER_ALL)) ? step_reg : 7'd0;
        it_twl = ((it_cs != 7'd0) && (it_ws != 7'd0)) ? tcl_reg : twl_reg;
        it_chk = (it_cs != 7'd0) || (it_ws != 7'd0);
        it_lvl = (it_cs != 7'd0) ? tcl_reg : it_twl;
        it_cond = it_chk && (((it_lvl <= HOLD_LOW) && down_reg) ||
                             ((it_lvl == LEVEL_MAX) && !down_reg));
        it_h   = hold_reg + 3'd1;
    end

    // set and button actions
    always_comb
    begin
        set_r = 1'b0; set_g = 1'b0; set_b = 1'b0; set_cl = 1'b0; set_wl = 1'b0;
        v_r = tr_reg; v_g = tg_reg; v_b = tb_reg; v_cl = tcl_reg; v_wl = twl_reg;
        emit = 1'b1;
        twl_next  = twl_reg;
        down_next = down_reg;
        hold_next = hold_reg;
        if (op_reg == OP_SET)
        begin
            set_r = 1'b1; set_g = 1'b1; set_b = 1'b1; set_cl = 1'b1; set_wl = 1'b1;
            v_r = r_in_reg; v_g = g_in_reg; v_b = b_in_reg;
            v_cl = sat100(cl_in_reg);
            v_wl = sat100(wl_in_reg);
        end
        else
        begin
            unique case (act_reg)
                ACT_ON:
                begin
                    set_cl = 1'b1; v_cl = rc_reg; set_wl = 1'b1; v_wl = rw_reg;
                end
                ACT_OFF:
                begin
                    set_cl = 1'b1; v_cl = 7'd0; set_wl = 1'b1; v_wl = 7'd0;
                end
                ACT_TOGGLE:
                begin
                    set_cl = 1'b1; v_cl = (tcl_reg != 7'd0) ? 7'd0 : rc_reg;
                    set_wl = 1'b1; v_wl = (twl_reg != 7'd0) ? 7'd0 : rw_reg;
                end
                ACT_BRIGHTEN:
                begin
                    set_cl = 1'b1;
                    v_cl = 7'(step_up({1'b0, tcl_reg}, step_reg, {1'b0, LEVEL_MAX}));
                    set_wl = 1'b1;
                    v_wl = 7'(step_up({1'b0, twl_reg}, step_reg, {1'b0, LEVEL_MAX}));
                end
                ACT_DIM:
                begin
                    set_cl = 1'b1; v_cl = 7'(step_down({1'b0, tcl_reg}, step_reg));
                    set_wl = 1'b1; v_wl = 7'(step_down({1'b0, twl_reg}, step_reg));
                end
                ACT_RED_UP:     begin set_r = 1'b1; v_r = step_up(tr_reg, step_reg, COLOR_MAX); end
                ACT_RED_DOWN:   begin set_r = 1'b1; v_r = step_down(tr_reg, step_reg); end
                ACT_GREEN_UP:   begin set_g = 1'b1; v_g = step_up(tg_reg, step_reg, COLOR_MAX); end
                ACT_GREEN_DOWN: begin set_g = 1'b1; v_g = step_down(tg_reg, step_reg); end
                ACT_BLUE_UP:    begin set_b = 1'b1; v_b = step_up(tb_reg, step_reg, COLOR_MAX); end
                ACT_BLUE_DOWN:  begin set_b = 1'b1; v_b = step_down(tb_reg, step_reg); end
                ACT_WHITE_UP:
                begin
                    set_wl = 1'b1;
                    v_wl = 7'(step_up({1'b0, twl_reg}, step_reg, {1'b0, LEVEL_MAX}));
                end
                ACT_WHITE_DOWN:
                begin
                    set_wl = 1'b1; v_wl = 7'(step_down({1'b0, twl_reg}, step_reg));
                end
                ACT_RGB_UP:
                begin
                    set_cl = 1'b1;
                    v_cl = 7'(step_up({1'b0, tcl_reg}, step_reg, {1'b0, LEVEL_MAX}));
                end
                ACT_RGB_DOWN:
                begin
                    set_cl = 1'b1; v_cl = 7'(step_down({1'b0, tcl_reg}, step_reg));
                end
                ACT_RGB_ON:   begin set_cl = 1'b1; v_cl = rc_reg; end
                ACT_RGB_OFF:  begin set_cl = 1'b1; v_cl = 7'd0; end
                ACT_RGB_TOGGLE:
                begin
                    set_cl = 1'b1; v_cl = (tcl_reg != 7'd0) ? 7'd0 : rc_reg;
                end
                ACT_WHITE_ON:  begin set_wl = 1'b1; v_wl = rw_reg; end
                ACT_WHITE_OFF: begin set_wl = 1'b1; v_wl = 7'd0; end
                ACT_WHITE_TOGGLE:
                begin
                    set_wl = 1'b1; v_wl = (twl_reg != 7'd0) ? 7'd0 : rw_reg;
                end
                ACT_RGB_DIMMED:
                begin
                    emit = (tcl_reg == 7'd0); set_cl = 1'b1; v_cl = dl;
                end
                ACT_WHITE_DIMMED:
                begin
                    emit = (twl_reg == 7'd0); set_wl = 1'b1; v_wl = dl;
                end
                ACT_ALL_DIMMED:
                begin
                    emit = (tcl_reg == 7'd0) && (twl_reg == 7'd0);
                    set_cl = 1'b1; v_cl = dl; set_wl = 1'b1; v_wl = dl;
                end
                ACT_ITER_RGB, ACT_ITER_WHITE, ACT_ITER_ALL:
                begin
                    twl_next = it_twl;
                    if (it_cond && (it_h != HOLD_ITEMS))
                    begin
                        // paused at an end of the range
                        hold_next = it_h;
                        emit      = 1'b0;
                    end
                    else
                    begin
                        if (it_cond)
                            down_next = !down_reg;
                        hold_next = 3'd0;
                        set_cl = 1'b1; set_wl = 1'b1;
                        if (it_cond ? !down_reg : down_reg)
                        begin
                            v_cl = 7'(step_down({1'b0, tcl_reg}, it_cs));
                            v_wl = 7'(step_down({1'b0, it_twl}, it_ws));
                        end
                        else
                        begin
                            v_cl = 7'(step_up({1'b0, tcl_reg}, it_cs, {1'b0, LEVEL_MAX}));
                            v_wl = 7'(step_up({1'b0, it_twl}, it_ws, {1'b0, LEVEL_MAX}));
                        end
                    end
                end
                default: emit = 1'b0;
            endcase
        end
        // target update for an emitting transaction
        tr_next  = (emit && set_r) ? v_r : tr_reg;
        tg_next  = (emit && set_g) ? v_g : tg_reg;
        tb_next  = (emit && set_b) ? v_b : tb_reg;
        tcl_next = (emit && set_cl) ? v_cl : tcl_reg;
        if (emit && set_wl)
            twl_next = v_wl;
        rc_next = (emit && set_cl && (v_cl != 7'd0)) ? v_cl : rc_reg;
        rw_next = (emit && set_wl && (v_wl != 7'd0)) ? v_wl : rw_reg;
    end

    // divider datapath
    always_comb
    begin
        sh1     = {rem1_reg, q1_reg[15]};
        sh1_sub = sh1 - {1'b0, ms_reg};
        sha     = {7'd0, rema_reg[7:0], qa_reg[7]};
        shb     = {7'd0, remb_reg[7:0], qb_reg[7]};
        div_eff = (q1_reg == 16'd0) ? 16'd1 : q1_reg;
        cs8     = (qa_reg == 8'd0) ? 8'd1 : qa_reg;
        ls8     = (qb_reg == 8'd0) ? 8'd1 : qb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div1_init)
        begin
            cnt_reg  <= DIV1_LAST;
            q1_reg   <= fade_reg;
            rem1_reg <= 16'd0;
        end
        else if (cmd.div1_step)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (sh1 >= {1'b0, ms_reg})
            begin
                rem1_reg <= sh1_sub[15:0];
                q1_reg   <= {q1_reg[14:0], 1'b1};
            end
            else
            begin
                rem1_reg <= sh1[15:0];
                q1_reg   <= {q1_reg[14:0], 1'b0};
            end
        end
        else if (cmd.div2_init)
        begin
            cnt_reg  <= DIV2_LAST;
            div_reg  <= div_eff;
            qa_reg   <= COLOR_MAX;
            qb_reg   <= {1'b0, LEVEL_MAX};
            rema_reg <= 9'd0;
            remb_reg <= 9'd0;
        end
        else if (cmd.div2_step)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (sha >= div_reg)
            begin
                rema_reg <= 9'(sha - div_reg);
                qa_reg   <= {qa_reg[6:0], 1'b1};
            end
            else
            begin
                rema_reg <= sha[8:0];
                qa_reg   <= {qa_reg[6:0], 1'b0};
            end
            if (shb >= div_reg)
            begin
                remb_reg <= 9'(shb - div_reg);
                qb_reg   <= {qb_reg[6:0], 1'b1};
            end
            else
            begin
                remb_reg <= shb[8:0];
                qb_reg   <= {qb_reg[6:0], 1'b0};
            end
        end
    end

    // fade ramp
    always_comb
    begin
        dr_next   = ramp(dr_reg, tr_reg, cs8);
        dg_next   = ramp(dg_reg, tg_reg, cs8);
        db_next   = ramp(db_reg, tb_reg, cs8);
        dcl8_next = ramp({1'b0, dcl_reg}, {1'b0, tcl_reg}, ls8);
        dwl8_next = ramp({1'b0, dwl_reg}, {1'b0, twl_reg}, ls8);
    end

    assign stat.ramp_changed = (dr_reg != tr_reg) || (dg_reg != tg_reg) ||
                               (db_reg != tb_reg) || (dcl_reg != tcl_reg) ||
                               (dwl_reg != twl_reg);

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tr_reg   <= 8'd0;
            tg_reg   <= 8'd255;
            tb_reg   <= 8'd0;
            tcl_reg  <= 7'd0;
            twl_reg  <= 7'd0;
            rc_reg   <= 7'd100;
            rw_reg   <= 7'd100;
            down_reg <= 1'b0;
            hold_reg <= 3'd0;
            dr_reg   <= 8'd0;
            dg_reg   <= 8'd255;
            db_reg   <= 8'd0;
            dcl_reg  <= 7'd0;
            dwl_reg  <= 7'd0;
        end
        else if (cmd.apply)
        begin
            tr_reg   <= tr_next;
            tg_reg   <= tg_next;
            tb_reg   <= tb_next;
            tcl_reg  <= tcl_next;
            twl_reg  <= twl_next;
            rc_reg   <= rc_next;
            rw_reg   <= rw_next;
            down_reg <= down_next;
            hold_reg <= hold_next;
        end
        else if (cmd.ramp)
        begin
            dr_reg  <= dr_next;
            dg_reg  <= dg_next;
            db_reg  <= db_next;
            dcl_reg <= dcl8_next[6:0];
            dwl_reg <= dwl8_next[6:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.apply && emit)
        begin
            o_kind_reg <= !stat.fade_off;
            o_last_reg <= !stat.fade_off;
            o_r_reg    <= tr_next;
            o_g_reg    <= tg_next;
            o_b_reg    <= tb_next;
            o_cl_reg   <= tcl_next;
            o_wl_reg   <= twl_next;
        end
        else if (cmd.load_report)
        begin
            o_kind_reg <= 1'b1;
            o_last_reg <= 1'b1;
            o_r_reg    <= tr_reg;
            o_g_reg    <= tg_reg;
            o_b_reg    <= tb_reg;
            o_cl_reg   <= tcl_reg;
            o_wl_reg   <= twl_reg;
        end
        else if (cmd.ramp)
        begin
            o_kind_reg <= 1'b0;
            o_last_reg <= 1'b1;
            o_r_reg    <= dr_next;
            o_g_reg    <= dg_next;
            o_b_reg    <= db_next;
            o_cl_reg   <= dcl8_next[6:0];
            o_wl_reg   <= dwl8_next[6:0];
        end
    end

    assign result_kind     = o_kind_reg;
    assign last            = o_last_reg;
    assign red_out         = o_r_reg;
    assign green_out       = o_g_reg;
    assign blue_out        = o_b_reg;
    assign color_level_out = o_cl_reg;
    assign white_level_out = o_wl_reg;

endmodule

>>> sv/rgbw_dimmer_with_fade_unit.sv
// Channel   Handshake            Payload
// input     in_valid / in_stall  operation, action_code, red_in .. white_level_in, elapsed_ms
// output    out_valid/ out_stall result_kind, red_out .. white_level_out, last
// config    cfg_we               cfg_index, cfg_data
//
// One transaction at a time. Set and button transactions pass decode and apply before the
// first result; a tick with nonzero fade_time and elapsed_ms runs the 16-step fade_time / elapsed
// divider followed by the 8-step divider for the color and level steps.
// Results wait in an output register; a stall holds it and the next result.
// Reset is asynchronous, active low, and restores the register and state defaults.
module rgbw_dimmer_with_fade_unit
    import rdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [4:0]  action_code,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  color_level_in,
    input  logic [7:0]  white_level_in,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [6:0]  color_level_out,
    output logic [6:0]  white_level_out,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rdf_cmd_t  cmd;
    rdf_stat_t stat;

    rdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rdf_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .action_code     (action_code),
        .red_in          (red_in),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .color_level_in  (color_level_in),
        .white_level_in  (white_level_in),
        .elapsed_ms      (elapsed_ms),
        .result_kind     (result_kind),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .color_level_out (color_level_out),
        .white_level_out (white_level_out),
        .last            (last)
    );

endmodule

>>> test/tb_rgbw_dimmer_with_fade_unit.sv
`timescale 1ns / 100ps

module tb_rgbw_dimmer_with_fade_unit;
    import rdf_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] clev;
        logic [6:0] wlev;
        logic       fin;
    } led_result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  act;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  cl;
        logic [7:0]  wl;
        logic [15:0] ms;
    } dimmer_cmd_t;

    // directed row: command plus optional typed-in first result
    typedef struct packed {
        dimmer_cmd_t cmd;
        logic        has_fixed;
        led_result_t fixed;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [4:0]  action_code = '0;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [7:0]  color_level_in = '0;
    logic [7:0]  white_level_in = '0;
    logic [15:0] elapsed_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [6:0]  color_level_out;
    logic [6:0]  white_level_out;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    rgbw_dimmer_with_fade_unit u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [6:0]  m_step, m_dimlev;
    logic [15:0] m_fade;
    logic [7:0]  t_r, t_g, t_b;
    logic [6:0]  t_cl, t_wl, mem_cl, mem_wl;
    logic        dim_dn;
    logic [2:0]  hold_cnt;
    logic [7:0]  d_r, d_g, d_b;
    logic [6:0]  d_cl, d_wl;

    led_result_t pending_leds[$];
    int          mismatches = 0;
    bit          quiet_tail = 1'b0;

    function automatic logic [6:0] lvl_sat(input int v);
        return (v > 100) ? 7'd100 : v[6:0];
    endfunction

    function automatic int up_clamp(input int v, input int s, input int lim);
        return (v + s > lim) ? lim : v + s;
    endfunction

    function automatic int dn_clamp(input int v, input int s);
        return (s > v) ? 0 : v - s;
    endfunction

    // negative keeps current target
    task automatic write_targets(input int r, input int g, input int b,
                                 input int cl, input int wl);
        led_result_t e;
        if (cl > 0) mem_cl = lvl_sat(cl);
        if (wl > 0) mem_wl = lvl_sat(wl);
        if (r >= 0) t_r = r[7:0];
        if (g >= 0) t_g = g[7:0];
        if (b >= 0) t_b = b[7:0];
        if (cl >= 0) t_cl = lvl_sat(cl);
        if (wl >= 0) t_wl = lvl_sat(wl);
        e = '{1'b0, t_r, t_g, t_b, t_cl, t_wl, 1'b0};
        if (m_fade == 0) pending_leds.push_back(e);
        e.kind = 1'b1;
        e.fin = 1'b1;
        pending_leds.push_back(e);
    endtask

    function automatic bit iter_held(input int lev);
        if ((lev <= 10 && dim_dn) || (lev == 100 && !dim_dn))
        begin
            hold_cnt = hold_cnt + 3'd1;
            if (hold_cnt == HOLD_ITEMS)
            begin
                dim_dn = !dim_dn;
                hold_cnt = 0;
                return 1'b0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic iterate_level(input int cs, input int ws);
        int cl, wl;
        if (cs > 0 && ws > 0) t_wl = t_cl;
        if (cs > 0)
        begin
            if (iter_held(t_cl)) return;
        end
        else if (ws > 0)
        begin
            if (iter_held(t_wl)) return;
        end
        hold_cnt = 0;
        if (dim_dn)
        begin
            cl = dn_clamp(t_cl, cs);
            wl = dn_clamp(t_wl, ws);
        end
        else
        begin
            cl = up_clamp(t_cl, cs, 100);
            wl = up_clamp(t_wl, ws, 100);
        end
        write_targets(-1, -1, -1, cl, wl);
    endtask

    function automatic logic [7:0] ramp_to(input logic [7:0] drv, input logic [7:0] tgt,
                                           input int st, inout bit ch);
        int dv, tv;
        dv = drv;
        tv = tgt;
        if (tv > dv)
        begin
            ch = 1'b1;
            return (dv + st > tv) ? tgt : 8'(dv + st);
        end
        if (tv < dv)
        begin
            ch = 1'b1;
            return (dv < tv + st) ? tgt : 8'(dv - st);
        end
        return drv;
    endfunction

    task automatic fade_tick(input int ms);
        int dv, cs, ls;
        bit ch;
        ch = 1'b0;
        if (m_fade == 0 || ms == 0) return;
        dv = m_fade / ms;
        if (dv == 0) dv = 1;
        cs = 255 / dv;
        ls = 100 / dv;
        if (cs < 1) cs = 1;
        if (ls < 1) ls = 1;
        d_r = ramp_to(d_r, t_r, cs, ch);
        d_g = ramp_to(d_g, t_g, cs, ch);
        d_b = ramp_to(d_b, t_b, cs, ch);
        d_cl = 7'(ramp_to({1'b0, d_cl}, {1'b0, t_cl}, ls, ch));
        d_wl = 7'(ramp_to({1'b0, d_wl}, {1'b0, t_wl}, ls, ch));
        if (ch) pending_leds.push_back('{1'b0, d_r, d_g, d_b, d_cl, d_wl, 1'b1});
    endtask

    task automatic predict_leds(input dimmer_cmd_t c);
        int s, dl, cl, wl;
        s = m_step;
        dl = lvl_sat(m_dimlev);
        cl = t_cl;
        wl = t_wl;
        case (c.op)
            OP_SET: write_targets(c.r, c.g, c.b, lvl_sat(c.cl), lvl_sat(c.wl));
            OP_TICK: fade_tick(c.ms);
            OP_ACTION:
            case (c.act)
                ACT_ON:           write_targets(-1, -1, -1, mem_cl, mem_wl);
                ACT_OFF:          write_targets(-1, -1, -1, 0, 0);
                ACT_TOGGLE:       write_targets(-1, -1, -1, cl > 0 ? 0 : mem_cl,
                                                wl > 0 ? 0 : mem_wl);
                ACT_BRIGHTEN:     write_targets(-1, -1, -1, up_clamp(cl, s, 100),
                                                up_clamp(wl, s, 100));
                ACT_DIM:          write_targets(-1, -1, -1, dn_clamp(cl, s), dn_clamp(wl, s));
                ACT_RED_UP:       write_targets(up_clamp(t_r, s, 255), -1, -1, -1, -1);
                ACT_RED_DOWN:     write_targets(dn_clamp(t_r, s), -1, -1, -1, -1);
                ACT_GREEN_UP:     write_targets(-1, up_clamp(t_g, s, 255), -1, -1, -1);
                ACT_GREEN_DOWN:   write_targets(-1, dn_clamp(t_g, s), -1, -1, -1);
                ACT_BLUE_UP:      write_targets(-1, -1, up_clamp(t_b, s, 255), -1, -1);
                ACT_BLUE_DOWN:    write_targets(-1, -1, dn_clamp(t_b, s), -1, -1);
                ACT_WHITE_UP:     write_targets(-1, -1, -1, -1, up_clamp(wl, s, 100));
                ACT_WHITE_DOWN:   write_targets(-1, -1, -1, -1, dn_clamp(wl, s));
                ACT_RGB_UP:       write_targets(-1, -1, -1, up_clamp(cl, s, 100), -1);
                ACT_RGB_DOWN:     write_targets(-1, -1, -1, dn_clamp(cl, s), -1);
                ACT_RGB_ON:       write_targets(-1, -1, -1, mem_cl, -1);
                ACT_RGB_OFF:      write_targets(-1, -1, -1, 0, -1);
                ACT_RGB_TOGGLE:   write_targets(-1, -1, -1, cl > 0 ? 0 : mem_cl, -1);
                ACT_WHITE_ON:     write_targets(-1, -1, -1, -1, mem_wl);
                ACT_WHITE_OFF:    write_targets(-1, -1, -1, -1, 0);
                ACT_WHITE_TOGGLE: write_targets(-1, -1, -1, -1, wl > 0 ? 0 : mem_wl);
                ACT_RGB_DIMMED:   if (cl == 0) write_targets(-1, -1, -1, dl, -1);
                ACT_WHITE_DIMMED: if (wl == 0) write_targets(-1, -1, -1, -1, dl);
                ACT_ALL_DIMMED:   if (cl == 0 && wl == 0) write_targets(-1, -1, -1, dl, dl);
                ACT_ITER_RGB:     iterate_level(s, 0);
                ACT_ITER_WHITE:   iterate_level(0, s);
                ACT_ITER_ALL:     iterate_level(s, s);
                default: ;
            endcase
            default: ;
        endcase
    endtask

    // configuration write, block must be idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_BUTTON_STEP:  m_step = val[6:0];
            CFG_DIMMED_LEVEL: m_dimlev = val[6:0];
            CFG_FADE_TIME:    m_fade = val;
            default: ;
        endcase
    endtask

    task automatic drain_idle();
        while (pending_leds.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // send one transaction, predict on acceptance
    task automatic send_cmd(input dimmer_cmd_t c, input bit has_fix, input led_result_t fx);
        int pre;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        operation = c.op;
        action_code = c.act;
        red_in = c.r;
        green_in = c.g;
        blue_in = c.b;
        color_level_in = c.cl;
        white_level_in = c.wl;
        elapsed_ms = c.ms;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pre = pending_leds.size();
        predict_leds(c);
        if (has_fix && pending_leds.size() > pre)
        begin
            pending_leds[pre] = fx;
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic dimmer_cmd_t rand_cmd();
        dimmer_cmd_t c;
        int p;
        c.r = 8'($urandom);
        c.g = 8'($urandom);
        c.b = 8'($urandom);
        c.cl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
        c.wl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
        c.act = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 26));
        p = $urandom_range(0, 99);
        c.ms = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        c.op = (p < 15) ? OP_SET : (p < 60) ? OP_ACTION : (p < 97) ? OP_TICK : 2'd3;
        return c;
    endfunction

    // output side: random stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_stall = 1'b0;
        end
    end

    // compare against oldest expectation
    always @(posedge clk)
    begin
        led_result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{result_kind, red_out, green_out, blue_out, color_level_out,
                    white_level_out, last};
            if (pending_leds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %h", got);
            end
            else
            begin
                want = pending_leds.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    cmd_row_t dir_rows[$];

    function automatic cmd_row_t mk(input logic [1:0] op, input logic [4:0] act,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] cl,
                                    input logic [7:0] wl, input logic [15:0] ms);
        cmd_row_t row;
        row.cmd = '{op, act, r, g, b, cl, wl, ms};
        row.has_fixed = 1'b0;
        row.fixed = '0;
        return row;
    endfunction

    initial
    begin
        cmd_row_t row;
        m_step = 7'd10; m_dimlev = 7'd20; m_fade = 16'd1000;
        t_r = 0; t_g = 8'd255; t_b = 0; t_cl = 0; t_wl = 0;
        mem_cl = 7'd100; mem_wl = 7'd100; dim_dn = 0; hold_cnt = 0;
        d_r = 0; d_g = 8'd255; d_b = 0; d_cl = 0; d_wl = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // directed: after reset, fade on, report only
        row = mk(OP_ACTION, ACT_ON, 0, 0, 0, 0, 0, 0);
        row.has_fixed = 1'b1;
        row.fixed = '{1'b1, 8'd0, 8'd255, 8'd0, 7'd100, 7'd100, 1'b1};
        dir_rows.push_back(row);
        row = mk(OP_SET, 0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd200, 0);
        row.has_fixed = 1'b1;
        row.fixed = '{1'b1, 8'd255, 8'd0, 8'd255, 7'd100, 7'd100, 1'b1};
        dir_rows.push_back(row);
        dir_rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'd0));
        dir_rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'd65535));
        dir_rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'd65535));
        dir_rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'd1));
        dir_rows.push_back(mk(OP_ACTION, ACT_RED_UP, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ACTION, ACT_GREEN_DOWN, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ACTION, ACT_RGB_DIMMED, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ACTION, ACT_OFF, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ACTION, ACT_ALL_DIMMED, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ACTION, 5'd31, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(2'd3, 0, 0, 0, 0, 0, 0, 0));
        for (int a = 0; a <= 26; a += 3)
            dir_rows.push_back(mk(OP_ACTION, a[4:0], 0, 0, 0, 0, 0, 0));
        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].has_fixed,
                                       dir_rows[i].fixed);
        drain_idle();

        // iterate hold with fade off, extremes of registers
        write_reg(CFG_FADE_TIME, 16'd0);
        write_reg(CFG_BUTTON_STEP, 16'd100);
        write_reg(CFG_DIMMED_LEVEL, 16'd127);
        for (int i = 0; i < 14; i++)
            send_cmd(mk(OP_ACTION, ACT_ITER_ALL, 0, 0, 0, 0, 0, 0).cmd, 1'b0, '0);
        send_cmd(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'd5).cmd, 1'b0, '0);
        drain_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_FADE_TIME, 16'd1000); write_reg(CFG_BUTTON_STEP, 16'd10); end
                1: begin write_reg(CFG_FADE_TIME, 16'd0); write_reg(CFG_BUTTON_STEP, 16'd0); end
                2: begin write_reg(CFG_FADE_TIME, 16'd65535); write_reg(CFG_BUTTON_STEP, 16'd127); end
                3: begin write_reg(CFG_FADE_TIME, 16'($urandom)); write_reg(CFG_DIMMED_LEVEL, 16'd0); end
                4: begin write_reg(CFG_FADE_TIME, 16'd1); write_reg(CFG_BUTTON_STEP, 16'd1); end
                default:
                begin
                    write_reg(CFG_FADE_TIME, 16'd300);
                    write_reg(CFG_BUTTON_STEP, 16'($urandom_range(1, 40)));
                    write_reg(CFG_DIMMED_LEVEL, 16'($urandom_range(0, 127)));
                    quiet_tail = 1'b1;
                end
            endcase
            for (int i = 0; i < 92; i++) send_cmd(rand_cmd(), 1'b0, '0);
            drain_idle();
        end

        if (mismatches == 0 && pending_leds.size() == 0)
        begin
            $display("rgbw_dimmer_with_fade_unit regression: pass");
        end
        else
        begin
            $display("rgbw_dimmer_with_fade_unit regression: fail");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("rgbw_dimmer_with_fade_unit regression: fail");
        $finish;
    end

endmodule
